FILE: design/pid2f_pkg.sv
// Shared types and constants of the two-form PID controller.
package pid2f_pkg;

   localparam int DATA_W = 32;
   localparam int TIME_W = 31;
   localparam int FRAC_W = 16;

   // Widest second operand of the serial multiplier: e - 2*prev + prev_prev needs 34 bits.
   localparam int MUL_B_W = 35;
   localparam int PROD_W = DATA_W + 1 + MUL_B_W;

   // Running sum of the output terms; three rounded products stay far below 2^53.
   localparam int TOT_W = 54;

   // Derivative quotient: 64-bit dividend, magnitude limited to 2^48.
   localparam int DIV_N_W = 64;
   localparam int DERIV_LIM_LOG = 48;
   localparam int DIV_RES_W = DERIV_LIM_LOG + 2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORM_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_WRAP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 3'd5;

   localparam logic ACTION_STEP = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   localparam logic FORM_POSITIONAL = 1'b0;
   localparam logic FORM_INCREMENTAL = 1'b1;

   // e*573 >= 1800*65536 holds exactly for e >= 205873
   localparam logic signed [DATA_W-1:0] WRAP_POS = 32'sd205873;
   localparam logic signed [DATA_W-1:0] WRAP_NEG = -32'sd205873;
   localparam logic signed [DATA_W-1:0] TWO_PI_Q = 32'sd411775;

   typedef struct packed {
      logic                     action;
      logic signed [DATA_W-1:0] measurement;
      logic [TIME_W-1:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     clipped;
   } rsp_type;

endpackage

FILE: design/pid2f_serial_mul.sv
// Bit-serial signed multiplier: one bit of the second operand per cycle.
module pid2f_serial_mul #(
   parameter int A_W = pid2f_pkg::DATA_W,
   parameter int B_W = pid2f_pkg::MUL_B_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [A_W-1:0]   a_val,
   input  logic signed [B_W-1:0]   b_val,
   output logic                    done,
   output logic signed [A_W+B_W:0] product
);

   localparam int CNT_W = $clog2(B_W);

   logic signed [A_W:0]   hi_ff, hi_in;
   logic [B_W-1:0]        lo_ff, lo_in;
   logic signed [A_W-1:0] mcand_ff, mcand_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic signed [A_W+1:0] hi_ext, addend, sum;
   logic                  last;

   always_comb begin
      last = (cnt_ff == CNT_W'(B_W - 1));
      hi_ext = {hi_ff[A_W], hi_ff};
      addend = lo_ff[0] ? {{2{mcand_ff[A_W-1]}}, mcand_ff} : '0;
      // top bit of b carries negative weight
      sum = last ? (hi_ext - addend) : (hi_ext + addend);

      hi_in = hi_ff;
      lo_in = lo_ff;
      mcand_in = mcand_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;

      if (start) begin
         hi_in = '0;
         lo_in = b_val;
         mcand_in = a_val;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         hi_in = sum[A_W+1:1];
         lo_in = {sum[0], lo_ff[B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign done = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

FILE: design/pid2f_serial_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero with a magnitude limit.
module pid2f_serial_div #(
   parameter int N_W = pid2f_pkg::DIV_N_W,
   parameter int D_W = pid2f_pkg::TIME_W,
   parameter int LIM_LOG = pid2f_pkg::DERIV_LIM_LOG
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [N_W-1:0]     num,
   input  logic [D_W-1:0]            den,
   output logic                      done,
   output logic signed [LIM_LOG+1:0] quot
);

   localparam int CNT_W = $clog2(N_W);

   logic [N_W-1:0]            mag_ff, mag_in;
   logic [D_W-1:0]            rem_ff, rem_in;
   logic [D_W-1:0]            den_ff, den_in;
   logic                      neg_ff, neg_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      run_ff, run_in;
   logic                      fin_ff, fin_in;
   logic                      done_ff, done_in;
   logic signed [LIM_LOG+1:0] quot_ff, quot_in;
   logic [D_W:0]              trial;
   logic [D_W+1:0]            diff;
   logic                      ge;
   logic                      last;
   logic                      big;
   logic [LIM_LOG+1:0]        clamp;

   always_comb begin
      trial = {rem_ff, mag_ff[N_W-1]};
      diff = {1'b0, trial} - {2'b00, den_ff};
      ge = ~diff[D_W+1];
      last = (cnt_ff == CNT_W'(N_W - 1));
      big = |mag_ff[N_W-1:LIM_LOG];
      clamp = big ? {2'b01, {LIM_LOG{1'b0}}} : {2'b00, mag_ff[LIM_LOG-1:0]};

      mag_in = mag_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      quot_in = quot_ff;

      if (start) begin
         mag_in = num[N_W-1] ? (-num) : num;
         rem_in = '0;
         den_in = den;
         neg_in = num[N_W-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // dividend bits leave at the top, quotient bits enter at the bottom
         mag_in = {mag_ff[N_W-2:0], ge};
         rem_in = ge ? diff[D_W-1:0] : trial[D_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         quot_in = neg_ff ? (-clamp) : clamp;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: design/pid_controller_two_form.sv
// Two-form PID controller top level: control sequencer, state and register file.
//
// Requests enter on req_ (valid/ready) and carry an action, a Q16.16 measurement and a
// time step in unsigned Q15.16. A control step request yields one response on rsp_ (drive
// and a clipped flag); a clear request zeroes the previous error and yields no response.
// Registers are written on csr_ (valid/ready, index and data), csr_ready is always high;
// write them only while no request is in flight.
// A control step runs on one bit-serial multiplier; each product takes a launch, one step
// per bit of the second operand, and a done step. Positional form uses four products and
// a serial divide for the derivative, skipped when the time step is zero. Incremental
// form uses three products. A clear request is completed in the idle state that takes it.
// One request is in work at a time.
// The response sits in an output register; a new request is accepted while it waits,
// and a finished result stalls in the last step until the receiver takes the old one.
// Reset clears the registers, the error history, the integral and the response valid.
module pid_controller_two_form (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  pid2f_pkg::req_type                      req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output pid2f_pkg::rsp_type                      rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pid2f_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pid2f_pkg::DATA_W-1:0]            csr_data
);

   localparam int DW = pid2f_pkg::DATA_W;
   localparam int TW = pid2f_pkg::TIME_W;
   localparam int BW = pid2f_pkg::MUL_B_W;
   localparam int PW = pid2f_pkg::PROD_W;
   localparam int SW = pid2f_pkg::TOT_W;
   localparam int FW = pid2f_pkg::FRAC_W;
   localparam int QW = pid2f_pkg::DIV_RES_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ERR     = 3'd1;
   localparam logic [2:0] ST_WRAP_HI = 3'd2;
   localparam logic [2:0] ST_WRAP_LO = 3'd3;
   localparam logic [2:0] ST_LAUNCH  = 3'd4;
   localparam logic [2:0] ST_MUL     = 3'd5;
   localparam logic [2:0] ST_DIV     = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   // product order of each form
   localparam logic [1:0] POS_OP_INTEG = 2'd0;
   localparam logic [1:0] POS_OP_DERIV = 2'd1;
   localparam logic [1:0] POS_OP_PROP  = 2'd2;
   localparam logic [1:0] POS_OP_INT   = 2'd3;
   localparam logic [1:0] INC_OP_PROP  = 2'd0;
   localparam logic [1:0] INC_OP_INT   = 2'd1;
   localparam logic [1:0] INC_OP_DERIV = 2'd2;

   localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

   function automatic logic word_fits(input logic [SW-1:0] x);
      word_fits = (&x[SW-1:DW-1]) | ~(|x[SW-1:DW-1]);
   endfunction

   function automatic logic [DW-1:0] sat_word(input logic [SW-1:0] x);
      if (word_fits(x)) begin
         sat_word = x[DW-1:0];
      end else begin
         sat_word = x[SW-1] ? WORD_MIN : WORD_MAX;
      end
   endfunction

   logic [2:0]           state_ff, state_in;
   logic                 form_ff, form_in;
   logic                 wrap_ff, wrap_in;
   logic signed [DW-1:0] setpoint_ff, setpoint_in;
   logic signed [DW-1:0] gain_p_ff, gain_p_in;
   logic signed [DW-1:0] gain_i_ff, gain_i_in;
   logic signed [DW-1:0] gain_d_ff, gain_d_in;
   logic signed [DW-1:0] prev_ff, prev_in;
   logic signed [DW-1:0] pprev_ff, pprev_in;
   logic signed [DW-1:0] integ_ff, integ_in;
   logic [1:0]           op_ff, op_in;
   logic                 flag_ff, flag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pid2f_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic signed [DW-1:0] meas_ff, meas_in;
   logic [TW-1:0]        dt_ff, dt_in;
   logic signed [DW-1:0] e_ff, e_in;
   logic [SW-1:0]        tot_ff, tot_in;

   logic [DW:0]          err_diff;
   logic [SW-1:0]        err_wide;
   logic signed [BW-1:0] e_ext, prev_ext, pprev_ext;
   logic signed [BW-1:0] diff1, diff2;
   logic signed [DW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic                 mul_start, mul_done;
   logic signed [PW-1:0] mul_prod;
   logic                 div_start, div_done;
   logic signed [QW-1:0] div_quot;
   logic                 is_integ_op, is_div_op, last_op;
   logic [SW-1:0]        rnd, add_base, add_sum;

   pid2f_serial_mul #(
      .A_W(pid2f_pkg::DATA_W),
      .B_W(pid2f_pkg::MUL_B_W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a_val  (mul_a),
      .b_val  (mul_b),
      .done   (mul_done),
      .product(mul_prod)
   );

   pid2f_serial_div #(
      .N_W    (pid2f_pkg::DIV_N_W),
      .D_W    (pid2f_pkg::TIME_W),
      .LIM_LOG(pid2f_pkg::DERIV_LIM_LOG)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (mul_prod[pid2f_pkg::DIV_N_W-1:0]),
      .den  (dt_ff),
      .done (div_done),
      .quot (div_quot)
   );

   // operand selection for the shared multiplier
   always_comb begin
      e_ext = {{(BW-DW){e_ff[DW-1]}}, e_ff};
      prev_ext = {{(BW-DW){prev_ff[DW-1]}}, prev_ff};
      pprev_ext = {{(BW-DW){pprev_ff[DW-1]}}, pprev_ff};
      diff1 = e_ext - prev_ext;
      diff2 = e_ext - (prev_ext <<< 1) + pprev_ext;

      mul_a = gain_d_ff;
      mul_b = diff2;
      if (form_ff == pid2f_pkg::FORM_POSITIONAL) begin
         case (op_ff)
            POS_OP_INTEG: begin
               mul_a = e_ff;
               mul_b = {{(BW-TW){1'b0}}, dt_ff};
            end
            POS_OP_DERIV: begin
               mul_a = gain_d_ff;
               mul_b = diff1;
            end
            POS_OP_PROP: begin
               mul_a = gain_p_ff;
               mul_b = e_ext;
            end
            default: begin
               mul_a = gain_i_ff;
               mul_b = {{(BW-DW){integ_ff[DW-1]}}, integ_ff};
            end
         endcase
      end else begin
         case (op_ff)
            INC_OP_PROP: begin
               mul_a = gain_p_ff;
               mul_b = diff1;
            end
            INC_OP_INT: begin
               mul_a = gain_i_ff;
               mul_b = e_ext;
            end
            default: begin
               mul_a = gain_d_ff;
               mul_b = diff2;
            end
         endcase
      end
   end

   always_comb begin
      is_integ_op = (form_ff == pid2f_pkg::FORM_POSITIONAL) && (op_ff == POS_OP_INTEG);
      is_div_op = (form_ff == pid2f_pkg::FORM_POSITIONAL) && (op_ff == POS_OP_DERIV);
      last_op = (form_ff == pid2f_pkg::FORM_POSITIONAL) ? (op_ff == POS_OP_INT)
                                                        : (op_ff == INC_OP_DERIV);

      // round half up: floor(p / 2^16) plus bit 15 as carry
      rnd = {{(SW-(PW-FW)){mul_prod[PW-1]}}, mul_prod[PW-1:FW]} + SW'(mul_prod[FW-1]);
      add_base = is_integ_op ? {{(SW-DW){integ_ff[DW-1]}}, integ_ff} : tot_ff;
      add_sum = add_base + rnd;

      err_diff = {setpoint_ff[DW-1], setpoint_ff} - {meas_ff[DW-1], meas_ff};
      err_wide = {{(SW-DW-1){err_diff[DW]}}, err_diff};
   end

   always_comb begin
      state_in = state_ff;
      form_in = form_ff;
      wrap_in = wrap_ff;
      setpoint_in = setpoint_ff;
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      prev_in = prev_ff;
      pprev_in = pprev_ff;
      integ_in = integ_ff;
      op_in = op_ff;
      flag_in = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      meas_in = meas_ff;
      dt_in = dt_ff;
      e_in = e_ff;
      tot_in = tot_ff;
      mul_start = 1'b0;
      div_start = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            pid2f_pkg::CSR_FORM_SELECT: form_in = csr_data[0];
            pid2f_pkg::CSR_ANGLE_WRAP:  wrap_in = csr_data[0];
            pid2f_pkg::CSR_SETPOINT:    setpoint_in = csr_data;
            pid2f_pkg::CSR_GAIN_P:      gain_p_in = csr_data;
            pid2f_pkg::CSR_GAIN_I:      gain_i_in = csr_data;
            pid2f_pkg::CSR_GAIN_D:      gain_d_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == pid2f_pkg::ACTION_CLEAR) begin
                  prev_in = '0;
               end else begin
                  meas_in = req_data.measurement;
                  dt_in = req_data.time_step;
                  tot_in = '0;
                  flag_in = 1'b0;
                  op_in = '0;
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            // wide difference saturates without raising clipped
            e_in = sat_word(err_wide);
            state_in = ST_WRAP_HI;
         end
         ST_WRAP_HI: begin
            if (wrap_ff && (e_ff >= pid2f_pkg::WRAP_POS)) begin
               e_in = e_ff - pid2f_pkg::TWO_PI_Q;
            end
            state_in = ST_WRAP_LO;
         end
         ST_WRAP_LO: begin
            if (wrap_ff && (e_ff <= pid2f_pkg::WRAP_NEG)) begin
               e_in = e_ff + pid2f_pkg::TWO_PI_Q;
            end
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            mul_start = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               if (is_integ_op) begin
                  integ_in = sat_word(add_sum);
                  if (!word_fits(add_sum)) begin
                     flag_in = 1'b1;
                  end
                  op_in = op_ff + 1'b1;
                  state_in = ST_LAUNCH;
               end else if (is_div_op) begin
                  // zero time step leaves the derivative term at zero
                  if (dt_ff != '0) begin
                     div_start = 1'b1;
                     state_in = ST_DIV;
                  end else begin
                     op_in = op_ff + 1'b1;
                     state_in = ST_LAUNCH;
                  end
               end else begin
                  tot_in = add_sum;
                  if (last_op) begin
                     state_in = ST_DONE;
                  end else begin
                     op_in = op_ff + 1'b1;
                     state_in = ST_LAUNCH;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               tot_in = tot_ff + {{(SW-QW){div_quot[QW-1]}}, div_quot};
               op_in = op_ff + 1'b1;
               state_in = ST_LAUNCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.drive = sat_word(tot_ff);
               rsp_data_in.clipped = flag_ff | ~word_fits(tot_ff);
               prev_in = e_ff;
               if (form_ff == pid2f_pkg::FORM_INCREMENTAL) begin
                  pprev_in = prev_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         form_ff <= pid2f_pkg::FORM_POSITIONAL;
         wrap_ff <= 1'b0;
         setpoint_ff <= '0;
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         prev_ff <= '0;
         pprev_ff <= '0;
         integ_ff <= '0;
         op_ff <= '0;
         flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         form_ff <= form_in;
         wrap_ff <= wrap_in;
         setpoint_ff <= setpoint_in;
         gain_p_ff <= gain_p_in;
         gain_i_ff <= gain_i_in;
         gain_d_ff <= gain_d_in;
         prev_ff <= prev_in;
         pprev_ff <= pprev_in;
         integ_ff <= integ_in;
         op_ff <= op_in;
         flag_ff <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      meas_ff <= meas_in;
      dt_ff <= dt_in;
      e_ff <= e_in;
      tot_ff <= tot_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: design/pid2f_checker.sv
// Port-level checks of the two-form PID controller, bound to the top level.
module pid2f_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input pid2f_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pid2f_pkg::rsp_type rsp_data
);

   logic step_acc, clear_acc;

   assign step_acc = req_valid && req_ready && (req_data.action == pid2f_pkg::ACTION_STEP);
   assign clear_acc = req_valid && req_ready && (req_data.action == pid2f_pkg::ACTION_CLEAR);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      step_acc |=> !req_ready)
      else $error("request taken while a control step is in work");

   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      clear_acc && !rsp_valid |=> !rsp_valid)
      else $error("clear request produced a response");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      step_acc && !rsp_valid |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("response earlier than the error and fold steps allow");

endmodule

bind pid_controller_two_form pid2f_checker u_pid2f_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

FILE: verif/tb_pid_controller_two_form.sv
// Testbench for the two-form PID controller: random and directed requests checked by a scoreboard.
class drive_tracker;
   localparam longint WRAP_SCALE = 64'sd573;
   localparam longint WRAP_LIMIT = 64'sd117964800;
   localparam longint TURN_Q = 64'sd411775;
   localparam longint DERIV_CAP = 64'sd281474976710656;

   logic form_sel = pid2f_pkg::FORM_POSITIONAL;
   logic wrap_on = 1'b0;
   logic signed [31:0] target = '0;
   logic signed [31:0] kp = '0;
   logic signed [31:0] ki = '0;
   logic signed [31:0] kd = '0;
   logic signed [31:0] err_last = '0;
   logic signed [31:0] err_older = '0;
   logic signed [31:0] err_sum = '0;
   pid2f_pkg::rsp_type drive_due[$];
   int fails = 0;

   function void write_reg(input logic [pid2f_pkg::CSR_IDX_W-1:0] idx,
                           input logic [pid2f_pkg::DATA_W-1:0] value);
      case (idx)
         pid2f_pkg::CSR_FORM_SELECT: form_sel = value[0];
         pid2f_pkg::CSR_ANGLE_WRAP:  wrap_on = value[0];
         pid2f_pkg::CSR_SETPOINT:    target = value;
         pid2f_pkg::CSR_GAIN_P:      kp = value;
         pid2f_pkg::CSR_GAIN_I:      ki = value;
         pid2f_pkg::CSR_GAIN_D:      kd = value;
         default: ;
      endcase
   endfunction

   function logic signed [31:0] clamp32(input logic signed [63:0] x, output logic hit);
      hit = 1'b0;
      if (x > 64'sd2147483647) begin
         hit = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (x < -64'sd2147483648) begin
         hit = 1'b1;
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // exact product, + half LSB, floor back to Q16.16
   function logic signed [63:0] round_mul(input logic signed [31:0] a,
                                          input logic signed [63:0] b);
      logic signed [95:0] wa, wb, p;
      wa = a;
      wb = b;
      p = wa * wb + 96'sd32768;
      return p[79:16];
   endfunction

   function void take_request(input pid2f_pkg::req_type r);
      logic signed [63:0] meas, dt, e, total, d, num, acc;
      logic hit, flag, ignore;
      pid2f_pkg::rsp_type want;
      if (r.action == pid2f_pkg::ACTION_CLEAR) begin
         err_last = '0;
         return;
      end
      flag = 1'b0;
      meas = r.measurement;
      dt = {33'd0, r.time_step};
      e = clamp32(target - meas, ignore);
      if (wrap_on) begin
         if (e * WRAP_SCALE >= WRAP_LIMIT) e = e - TURN_Q;
         if (e * WRAP_SCALE <= -WRAP_LIMIT) e = e + TURN_Q;
      end
      if (form_sel == pid2f_pkg::FORM_POSITIONAL) begin
         acc = err_sum + round_mul(e[31:0], dt);
         err_sum = clamp32(acc, hit);
         flag |= hit;
         d = '0;
         if (dt != 0) begin
            num = kd * (e - err_last);
            d = num / dt;
            if (d > DERIV_CAP) d = DERIV_CAP;
            if (d < -DERIV_CAP) d = -DERIV_CAP;
         end
         total = round_mul(kp, e) + round_mul(ki, err_sum) + d;
         err_last = e[31:0];
      end else begin
         total = round_mul(kp, e - err_last) + round_mul(ki, e)
               + round_mul(kd, e - 2 * err_last + err_older);
         err_older = err_last;
         err_last = e[31:0];
      end
      want.drive = clamp32(total, hit);
      want.clipped = flag | hit;
      drive_due.push_back(want);
   endfunction

   function void check_drive(input pid2f_pkg::rsp_type got);
      pid2f_pkg::rsp_type want;
      if (drive_due.size() == 0) begin
         $display("%0t: response with no request pending: drive %0d clipped %0b",
                  $time, got.drive, got.clipped);
         fails++;
         return;
      end
      want = drive_due.pop_front();
      if (got.drive !== want.drive) begin
         $display("%0t: drive expected %0d, got %0d", $time, want.drive, got.drive);
         fails++;
      end
      if (got.clipped !== want.clipped) begin
         $display("%0t: clipped expected %0b, got %0b", $time, want.clipped, got.clipped);
         fails++;
      end
   endfunction

   function int outstanding();
      return drive_due.size();
   endfunction
endclass

module tb_pid_controller_two_form;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pid2f_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pid2f_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pid2f_pkg::CSR_IDX_W-1:0] csr_index = pid2f_pkg::CSR_FORM_SELECT;
   logic [pid2f_pkg::DATA_W-1:0] csr_data = '0;

   drive_tracker tracker = new();
   logic signed [31:0] cur_target = '0;
   int req_count = 0;
   int rsp_count = 0;

   localparam logic signed [31:0] MAX_Q = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MIN_Q = 32'sh80000000;

   pid_controller_two_form DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic pid2f_pkg::req_type make_req(input logic act,
                                                   input logic signed [31:0] meas,
                                                   input logic [pid2f_pkg::TIME_W-1:0] dt);
      pid2f_pkg::req_type r;
      r.action = act;
      r.measurement = meas;
      r.time_step = dt;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_gain();
      case ($urandom_range(9))
         0: return '0;
         1: return MAX_Q;
         2: return MIN_Q;
         3, 4: return $urandom;
         default: return int'($urandom_range(524288)) - 262144;
      endcase
   endfunction

   task automatic send_req(input pid2f_pkg::req_type item);
      // no idling while requests 400..549 go in
      while ($urandom_range(99) < ((req_count >= 400 && req_count < 550) ? 0 : 18)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(item);
      req_count++;
   endtask

   task automatic csr_put(input logic [pid2f_pkg::CSR_IDX_W-1:0] idx,
                          input logic [pid2f_pkg::DATA_W-1:0] value);
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, value);
   endtask

   task automatic program_regs(input logic form, input logic wrap,
                               input logic signed [31:0] sp, kp, ki, kd);
      logic [31:0] noise;
      noise = $urandom;
      csr_valid <= 1'b1;
      // upper bits of the one-bit registers carry junk
      csr_put(pid2f_pkg::CSR_FORM_SELECT, {noise[31:1], form});
      csr_put(pid2f_pkg::CSR_ANGLE_WRAP, {noise[30:0], wrap});
      csr_put(pid2f_pkg::CSR_SETPOINT, sp);
      csr_put(pid2f_pkg::CSR_GAIN_P, kp);
      csr_put(pid2f_pkg::CSR_GAIN_I, ki);
      csr_put(pid2f_pkg::CSR_GAIN_D, kd);
      csr_valid <= 1'b0;
      cur_target = sp;
   endtask

   // wait for every response, then pad before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   initial begin : rsp_side
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            tracker.check_drive(rsp_data);
            rsp_count++;
         end
         if (!held && rsp_count == 300) begin
            held = 1'b1;
            hold_left = 1500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_count >= 700 && rsp_count < 850) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 18);
         end
      end
   end

   initial begin : stimulus
      logic signed [31:0] sp, meas;
      logic [pid2f_pkg::TIME_W-1:0] dt;
      int offs;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // positional, angle fold on, unit-ish gains
      program_regs(pid2f_pkg::FORM_POSITIONAL, 1'b1, 32'sd0, 32'sd65536, 32'sd32768,
                   32'sd16384);
      send_req(make_req(pid2f_pkg::ACTION_STEP, -32'sd205873, 31'd65536));
      send_req(make_req(pid2f_pkg::ACTION_STEP, -32'sd205872, 31'd65536));
      // folds down, then lands low enough to fold back up
      send_req(make_req(pid2f_pkg::ACTION_STEP, -32'sd205890, 31'd65536));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd205873, 31'd65536));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd205872, 31'd0));
      send_req(make_req(pid2f_pkg::ACTION_CLEAR, 32'sd777, 31'd3));
      send_req(make_req(pid2f_pkg::ACTION_STEP, MAX_Q, '1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, MIN_Q, '1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd0, 31'd1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd12345, 31'd0));
      drain();

      program_regs(pid2f_pkg::FORM_INCREMENTAL, 1'b0, MAX_Q, MAX_Q, MIN_Q, MAX_Q);
      send_req(make_req(pid2f_pkg::ACTION_STEP, MIN_Q, 31'd1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, MAX_Q, 31'd1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd0, 31'd0));
      send_req(make_req(pid2f_pkg::ACTION_CLEAR, MIN_Q, '1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, -32'sd1, '1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, MIN_Q, 31'd65536));
      drain();

      program_regs(pid2f_pkg::FORM_POSITIONAL, 1'b0, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      send_req(make_req(pid2f_pkg::ACTION_STEP, MAX_Q, 31'd1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, MIN_Q, 31'd1));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd0, 31'd0));
      send_req(make_req(pid2f_pkg::ACTION_CLEAR, 32'sd0, 31'd0));
      send_req(make_req(pid2f_pkg::ACTION_STEP, 32'sd1, 31'd1));
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) begin
            program_regs(pid2f_pkg::FORM_POSITIONAL, 1'b1, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
         end else if (ph == 1) begin
            program_regs(pid2f_pkg::FORM_INCREMENTAL, 1'b1, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
         end else begin
            case ($urandom_range(3))
               0: sp = '0;
               1: sp = int'($urandom_range(1048576)) - 524288;
               2: sp = $urandom;
               default: sp = $urandom_range(1) ? MAX_Q : MIN_Q;
            endcase
            program_regs(1'($urandom_range(1)), 1'($urandom_range(1)), sp,
                         rand_gain(), rand_gain(), rand_gain());
         end
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(99) < 8) begin
               send_req(make_req(pid2f_pkg::ACTION_CLEAR, $urandom, 31'($urandom)));
            end else begin
               case ($urandom_range(9))
                  0: meas = MAX_Q;
                  1: meas = MIN_Q;
                  2, 3: meas = $urandom;
                  4, 5: begin
                     // error right around the fold threshold
                     offs = 205843 + int'($urandom_range(60));
                     meas = $urandom_range(1) ? cur_target - offs : cur_target + offs;
                  end
                  default: meas = cur_target + int'($urandom_range(524288)) - 262144;
               endcase
               case ($urandom_range(49))
                  0: dt = '0;
                  1: dt = '1;
                  2, 3, 4, 5, 6: dt = 31'($urandom);
                  default: dt = 31'($urandom_range(131072, 1));
               endcase
               send_req(make_req(pid2f_pkg::ACTION_STEP, meas, dt));
            end
         end
         drain();
      end

      if (tracker.fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
